// ----- rtl/gbm_pkg.sv -----
// gbm_pkg: shared types and codes of the gear and boost mode controller
// no dependencies; used by every module in rtl/
package gbm_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SPEED_W     = 16;
	localparam int LIMIT_W     = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_BOOST_ON      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_ON    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_REV_SPEED = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOOST_DUR     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BOOST_COOL    = 3'd4;

	localparam logic [LIMIT_W-1:0] BOOST_DUR_RST  = 16'd1000;
	localparam logic [LIMIT_W-1:0] BOOST_COOL_RST = 16'd1000;

	localparam logic [1:0] GEAR_N = 2'd0;
	localparam logic [1:0] GEAR_D = 2'd1;
	localparam logic [1:0] GEAR_R = 2'd2;

	localparam logic [1:0] PH_READY  = 2'd0;
	localparam logic [1:0] PH_ACTIVE = 2'd1;
	localparam logic [1:0] PH_COOL   = 2'd2;

	typedef struct packed {
		logic                      boost_on;
		logic                      reverse_on;
		logic signed [SPEED_W-1:0] max_rev_speed;
		logic [LIMIT_W-1:0]        boost_dur;
		logic [LIMIT_W-1:0]        boost_cool;
	} cfg_t;

	typedef struct packed {
		logic                      servo_on;
		logic                      reverse_pressed;
		logic                      boost_pressed;
		logic signed [SPEED_W-1:0] motor_speed;
		logic                      throttle_released;
	} tick_t;

endpackage

// ----- rtl/gbm_cfg_regs.sv -----
// gbm_cfg_regs: configuration register bank written through the cfg channel
// depends on gbm_pkg
module gbm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output gbm_pkg::cfg_t                   cfg
);

	gbm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boost_on      <= 1'b0;
			cfg_q.reverse_on    <= 1'b0;
			cfg_q.max_rev_speed <= '0;
			cfg_q.boost_dur     <= gbm_pkg::BOOST_DUR_RST;
			cfg_q.boost_cool    <= gbm_pkg::BOOST_COOL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gbm_pkg::REG_BOOST_ON:      cfg_q.boost_on      <= cfg_data[0];
				gbm_pkg::REG_REVERSE_ON:    cfg_q.reverse_on    <= cfg_data[0];
				gbm_pkg::REG_MAX_REV_SPEED: cfg_q.max_rev_speed <= $signed(cfg_data);
				gbm_pkg::REG_BOOST_DUR:     cfg_q.boost_dur     <= cfg_data;
				gbm_pkg::REG_BOOST_COOL:    cfg_q.boost_cool    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/gbm_fsm.sv -----
// gbm_fsm: gear and boost state registers with their one-tick update logic
// depends on gbm_pkg
module gbm_fsm #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd,
	input  gbm_pkg::tick_t tick,
	input  gbm_pkg::cfg_t  cfg,
	output logic [1:0]     gear_state,
	output logic [1:0]     boost_phase
);

	localparam int CW = (TIMER_WIDTH > gbm_pkg::LIMIT_W) ? TIMER_WIDTH : gbm_pkg::LIMIT_W;

	logic [1:0]             gear_q, gear_n;
	logic [1:0]             phase_q, phase_n, phase_t;
	logic [TIMER_WIDTH-1:0] bticks_q, bticks_n;
	logic [TIMER_WIDTH-1:0] cticks_q, cticks_n;
	logic                   b_done, c_done, rev_ok, boost_ok;

	always_comb begin
		b_done = (CW'(bticks_q) >= CW'(cfg.boost_dur))  || (&bticks_q);
		c_done = (CW'(cticks_q) >= CW'(cfg.boost_cool)) || (&cticks_q);
	end

	// boost timers first
	always_comb begin
		phase_t  = phase_q;
		bticks_n = bticks_q;
		cticks_n = cticks_q;
		case (phase_q)
			gbm_pkg::PH_COOL: begin
				if (c_done) begin
					cticks_n = '0;
					phase_t  = gbm_pkg::PH_READY;
				end else begin
					cticks_n = cticks_q + 1'b1;
				end
			end
			gbm_pkg::PH_ACTIVE: begin
				if (b_done || !cfg.boost_on) begin
					bticks_n = '0;
					phase_t  = gbm_pkg::PH_COOL;
				end else begin
					bticks_n = bticks_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// then gear transitions
	always_comb begin
		rev_ok   = tick.reverse_pressed && cfg.reverse_on &&
			(tick.motor_speed <= cfg.max_rev_speed) && tick.throttle_released;
		boost_ok = tick.boost_pressed && cfg.boost_on && (phase_t == gbm_pkg::PH_READY);
		gear_n   = gear_q;
		phase_n  = phase_t;
		case (gear_q)
			gbm_pkg::GEAR_N: begin
				if (tick.servo_on) gear_n = gbm_pkg::GEAR_D;
			end
			gbm_pkg::GEAR_D: begin
				priority if (!tick.servo_on) gear_n = gbm_pkg::GEAR_N;
				else if (rev_ok)             gear_n = gbm_pkg::GEAR_R;
				else if (boost_ok)           phase_n = gbm_pkg::PH_ACTIVE;
				else                         phase_n = phase_t;
			end
			gbm_pkg::GEAR_R: begin
				priority if (!tick.servo_on)     gear_n = gbm_pkg::GEAR_N;
				else if (!tick.reverse_pressed) gear_n = gbm_pkg::GEAR_D;
				else                            gear_n = gear_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q   <= gbm_pkg::GEAR_N;
			phase_q  <= gbm_pkg::PH_READY;
			bticks_q <= '0;
			cticks_q <= '0;
		end else if (upd) begin
			gear_q   <= gear_n;
			phase_q  <= phase_n;
			bticks_q <= bticks_n;
			cticks_q <= cticks_n;
		end
	end

	assign gear_state  = gear_q;
	assign boost_phase = phase_q;

	a_bticks_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		(bticks_q != '0) |-> (phase_q == gbm_pkg::PH_ACTIVE))
		else $error("boost counter running outside active phase");

	a_cticks_only_cool: assert property (@(posedge clk) disable iff (!arst_n)
		(cticks_q != '0) |-> (phase_q == gbm_pkg::PH_COOL))
		else $error("cooldown counter running outside cooldown phase");

	a_boost_off_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && phase_q == gbm_pkg::PH_ACTIVE && !cfg.boost_on)
		|=> (phase_q == gbm_pkg::PH_COOL))
		else $error("active boost held with feature disabled");

	a_no_neutral_to_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && gear_q == gbm_pkg::GEAR_N) |=> (gear_q != gbm_pkg::GEAR_R))
		else $error("neutral shifted straight into reverse");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> ($stable(gear_q) && $stable(phase_q)))
		else $error("state changed without an item");

endmodule

// ----- rtl/gear_and_boost_mode_fsm_top.sv -----
// gear_and_boost_mode_fsm_top: gear and boost mode controller, top level
// depends on gbm_pkg, gbm_cfg_regs, gbm_fsm
//
// usage
//   in channel  : one control tick per item (servo_on, reverse_pressed,
//                 boost_pressed, motor_speed, throttle_released)
//   out channel : one item per input item, the gear and boost_status after it
//   cfg channel : cfg_index selects the register, cfg_data is written;
//                 always ready, write only while no item is in flight
// datapath: an accepted item sits in the input register and its result is
//   loaded into the gear/boost state register, together with out_valid,
//   once that output register is empty or the receiver is ready
// throughput: 1 item per cycle while the receiver is ready; the state update
//   is one short combinational step between the input register and the
//   gear/boost state register, which also serves as the output register
// stall: while out_ready is low the result holds, the input register still
//   takes one more item, then in_ready drops
// reset: gear neutral, boost ready, counters zero, registers to defaults
module gear_and_boost_mode_fsm_top #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            servo_on,
	input  logic                            reverse_pressed,
	input  logic                            boost_pressed,
	input  logic signed [gbm_pkg::SPEED_W-1:0] motor_speed,
	input  logic                            throttle_released,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      gear,
	output logic [1:0]                      boost_status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	gbm_pkg::cfg_t  cfg;
	gbm_pkg::tick_t tick_s1;
	logic           v_s1, out_valid_q, advance, upd;

	assign advance   = !out_valid_q || out_ready;
	assign upd       = v_s1 && advance;
	assign in_ready  = !v_s1 || advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (advance)  out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.servo_on          <= servo_on;
			tick_s1.reverse_pressed   <= reverse_pressed;
			tick_s1.boost_pressed     <= boost_pressed;
			tick_s1.motor_speed       <= motor_speed;
			tick_s1.throttle_released <= throttle_released;
		end
	end

	gbm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gbm_fsm #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.tick        (tick_s1),
		.cfg         (cfg),
		.gear_state  (gear),
		.boost_phase (boost_status)
	);

endmodule
